// ===== design/xoshiro256_plus_generator_unit_macros.svh =====
// Assertion helpers used by the generator control module.
`ifndef XOSHIRO256_PLUS_GENERATOR_UNIT_MACROS_SVH
`define XOSHIRO256_PLUS_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define XPG_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xpg assertion failed");

// Next-cycle implication, disabled while in reset.
`define XPG_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xpg assertion failed");

`endif

// ===== design/xpg_pkg.sv =====
package xpg_pkg;

  localparam int unsigned WORD_W   = 64;
  localparam int unsigned HALF_W   = 32;
  localparam int unsigned FRAC_W   = 52;
  localparam int unsigned FRAC_SH  = 12;
  localparam int unsigned NUM_WORDS = 4;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned OUT_DATA_W = 120;  // 64 + 52, padded to bytes

  // splitmix64 constants
  localparam logic [WORD_W-1:0] MIX_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WORD_W-1:0] MIX_MUL_A = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WORD_W-1:0] MIX_MUL_B = 64'h94D0_49BB_1331_11EB;

  // Input kind carried in tuser
  localparam logic MODE_DRAW = 1'b0;
  localparam logic MODE_SEED = 1'b1;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_DRAW,       // emit s0 + s3, advance state
    OP_LOAD_SEED,  // acc <= seed
    OP_ADD_XOR30,  // acc += gamma; z = acc ^ (acc >> 30)
    OP_MUL,        // one partial product of z * const
    OP_XOR27,      // z = r ^ (r >> 27)
    OP_STORE       // word[idx] = r ^ (r >> 31)
  } op_e;

  typedef struct packed {
    op_e              op;
    logic             mul_sel_b;  // 0: MIX_MUL_A, 1: MIX_MUL_B
    logic [1:0]       mul_phase;  // 0: lo*lo, 1: lo*hi, 2: hi*lo
    logic [IDX_W-1:0] word_idx;
  } cmd_t;

endpackage

// ===== design/xpg_datapath.sv =====
module xpg_datapath
  import xpg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  input  logic [WORD_W-1:0]     seed_i,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  logic [WORD_W-1:0] words_q [NUM_WORDS];
  logic [WORD_W-1:0] acc_q, acc_d;
  logic [WORD_W-1:0] z_q, z_d;
  logic [WORD_W-1:0] r_q, r_d;
  logic [WORD_W-1:0] sum_q;

  logic [WORD_W-1:0] sum_now;
  logic [WORD_W-1:0] acc_inc;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [WORD_W-1:0] mul_p;
  logic [WORD_W-1:0] mul_k;
  logic [WORD_W-1:0] t17, w0x, w1x, w2x, w3x;

  // xoshiro256 update terms
  assign sum_now = words_q[0] + words_q[3];
  assign t17     = words_q[1] << 17;
  assign w2x     = words_q[2] ^ words_q[0];
  assign w3x     = words_q[3] ^ words_q[1];
  assign w1x     = words_q[1] ^ w2x;
  assign w0x     = words_q[0] ^ w3x;

  // Shared 32x32 multiplier for the splitmix64 products
  assign mul_k = cmd_i.mul_sel_b ? MIX_MUL_B : MIX_MUL_A;
  assign mul_a = (cmd_i.mul_phase == 2'd2) ? z_q[WORD_W-1:HALF_W] : z_q[HALF_W-1:0];
  assign mul_b = (cmd_i.mul_phase == 2'd1) ? mul_k[WORD_W-1:HALF_W] : mul_k[HALF_W-1:0];
  assign mul_p = WORD_W'(mul_a) * WORD_W'(mul_b);

  assign acc_inc = acc_q + MIX_GAMMA;

  // Seeding registers next values
  always_comb begin
    acc_d = acc_q;
    z_d   = z_q;
    r_d   = r_q;
    case (cmd_i.op)
      OP_LOAD_SEED: acc_d = seed_i;
      OP_ADD_XOR30: begin
        acc_d = acc_inc;
        z_d   = acc_inc ^ (acc_inc >> 30);
      end
      OP_MUL: begin
        if (cmd_i.mul_phase == 2'd0) begin
          r_d = mul_p;
        end else begin
          r_d = r_q + {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};
        end
      end
      OP_XOR27: z_d = r_q ^ (r_q >> 27);
      default: ;
    endcase
  end

  // Accumulator starts at zero so the reset pass seeds with zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q <= z_d;
    r_q <= r_d;
  end

  // State words and output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_DRAW) begin
      sum_q      <= sum_now;
      words_q[0] <= w0x;
      words_q[1] <= w1x;
      words_q[2] <= w2x ^ t17;
      words_q[3] <= {w3x[WORD_W-46:0], w3x[WORD_W-1:WORD_W-45]};
    end else if (cmd_i.op == OP_STORE) begin
      words_q[cmd_i.word_idx] <= r_q ^ (r_q >> 31);
    end
  end

  // tdata: random_word [63:0], unit_fraction [115:64], zero pad
  assign out_data_o = {{(OUT_DATA_W - WORD_W - FRAC_W){1'b0}},
                       sum_q[WORD_W-1:FRAC_SH], sum_q};

endmodule

// ===== design/xpg_ctrl.sv =====
`include "xoshiro256_plus_generator_unit_macros.svh"

module xpg_ctrl
  import xpg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_mode_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SEED = 1'b1;

  // Steps of one splitmix64 output
  localparam logic [3:0] STEP_ADD   = 4'd0;
  localparam logic [3:0] STEP_MA0   = 4'd1;
  localparam logic [3:0] STEP_MA1   = 4'd2;
  localparam logic [3:0] STEP_MA2   = 4'd3;
  localparam logic [3:0] STEP_X27   = 4'd4;
  localparam logic [3:0] STEP_MB0   = 4'd5;
  localparam logic [3:0] STEP_MB1   = 4'd6;
  localparam logic [3:0] STEP_MB2   = 4'd7;
  localparam logic [3:0] STEP_STORE = 4'd8;

  localparam logic [IDX_W-1:0] LAST_WORD = IDX_W'(NUM_WORDS - 1);

  logic             state_q, state_d;
  logic [3:0]       step_q, step_d;
  logic [IDX_W-1:0] word_q, word_d;
  logic             out_valid_q, out_valid_d;
  logic             in_fire, draw_fire, seed_fire;
  logic             seed_done;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign draw_fire   = in_fire && (in_mode_i == MODE_DRAW);
  assign seed_fire   = in_fire && (in_mode_i == MODE_SEED);
  assign seed_done   = (state_q == ST_SEED) && (step_q == STEP_STORE) && (word_q == LAST_WORD);
  assign out_valid_o = out_valid_q;

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    word_d  = word_q;
    if (state_q == ST_IDLE) begin
      if (seed_fire) begin
        state_d = ST_SEED;
        step_d  = STEP_ADD;
        word_d  = '0;
      end
    end else if (step_q == STEP_STORE) begin
      step_d = STEP_ADD;
      word_d = word_q + 1'b1;
      if (word_q == LAST_WORD) begin
        state_d = ST_IDLE;
      end
    end else begin
      step_d = step_q + 4'd1;
    end
  end

  // Output beat valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (draw_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Command decode
  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = OP_NONE;
    cmd_o.word_idx  = word_q;
    if (state_q == ST_IDLE) begin
      if (draw_fire) begin
        cmd_o.op = OP_DRAW;
      end else if (seed_fire) begin
        cmd_o.op = OP_LOAD_SEED;
      end
    end else begin
      case (step_q)
        STEP_ADD:   cmd_o.op = OP_ADD_XOR30;
        STEP_MA0: begin
          cmd_o.op = OP_MUL;
          cmd_o.mul_phase = 2'd0;
        end
        STEP_MA1: begin
          cmd_o.op = OP_MUL;
          cmd_o.mul_phase = 2'd1;
        end
        STEP_MA2: begin
          cmd_o.op = OP_MUL;
          cmd_o.mul_phase = 2'd2;
        end
        STEP_X27:   cmd_o.op = OP_XOR27;
        STEP_MB0: begin
          cmd_o.op = OP_MUL;
          cmd_o.mul_sel_b = 1'b1;
          cmd_o.mul_phase = 2'd0;
        end
        STEP_MB1: begin
          cmd_o.op = OP_MUL;
          cmd_o.mul_sel_b = 1'b1;
          cmd_o.mul_phase = 2'd1;
        end
        STEP_MB2: begin
          cmd_o.op = OP_MUL;
          cmd_o.mul_sel_b = 1'b1;
          cmd_o.mul_phase = 2'd2;
        end
        STEP_STORE: cmd_o.op = OP_STORE;
        default:    cmd_o.op = OP_NONE;
      endcase
    end
  end

  // Reset runs a seeding pass from zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SEED;
      step_q      <= STEP_ADD;
      word_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      word_q      <= word_d;
      out_valid_q <= out_valid_d;
    end
  end

  `XPG_ASSERT_IMPL(a_no_accept_while_seeding, clk_i, rst_ni, state_q == ST_SEED, !in_ready_o)
  `XPG_ASSERT_NEXT(a_draw_gives_beat, clk_i, rst_ni, draw_fire, out_valid_q)
  `XPG_ASSERT_NEXT(a_seed_ends_idle, clk_i, rst_ni, seed_done, state_q == ST_IDLE)
  `XPG_ASSERT_IMPL(a_step_in_range, clk_i, rst_ni, state_q == ST_SEED, step_q <= STEP_STORE)

endmodule

// ===== design/xoshiro256_plus_generator_unit.sv =====
// xoshiro256+ random generator with splitmix64 seeding. Each input beat is a
// draw (tuser 0) or a reseed (tuser 1, seed in tdata). A draw's result beat
// appears in the cycle after the draw is taken; draws stream at one per
// cycle while the output side keeps up. A reseed produces no output beat and
// holds tready low after it is taken while it builds four splitmix64 outputs,
// each of 9 steps, with each 64-bit product built from three passes through
// one shared 32x32 multiplier. After reset the same pass runs with seed zero
// before the first beat is accepted.
module xoshiro256_plus_generator_unit
  import xpg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [WORD_W-1:0]     s_axis_tdata,   // [63:0] seed_value
  input  logic                  s_axis_tuser,   // [0] mode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // [63:0] random_word, [115:64] unit_fraction
);

  cmd_t cmd;

  xpg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_mode_i   (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  xpg_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .seed_i     (s_axis_tdata),
    .out_data_o (m_axis_tdata)
  );

endmodule

// ===== test/xoshiro256_plus_generator_unit_test.sv =====
module xoshiro256_plus_generator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import xpg_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned DRAIN_LIMIT  = 20_000;
  localparam int unsigned SETTLE_TIME  = 48;   // longer than one reseed pass
  localparam int unsigned RANDOM_BEATS = 930;

  // Output-side stall styles
  typedef enum logic [1:0] {
    RX_OPEN,      // always ready
    RX_COIN,      // ready half the time
    RX_SPARSE,    // ready a quarter of the time on average
    RX_PERIODIC   // stalled three eighths of the time, in a fixed pattern
  } rx_style_e;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [FRAC_W-1:0] fraction;
  } draw_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [WORD_W-1:0]     s_axis_tdata;   // [63:0] seed_value
  logic                  s_axis_tuser;   // [0] mode
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // [63:0] random_word, [115:64] unit_fraction

  logic [WORD_W-1:0] rng_state [NUM_WORDS];
  draw_result_t      pending_draws [$];
  int unsigned       fail_count;
  int unsigned       cycle_count;
  int unsigned       burst_left;
  rx_style_e         rx_style;
  int unsigned       rx_hold;
  int unsigned       rx_phase;

  xoshiro256_plus_generator_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Generator model
  // ---------------------------------------------------------------------------

  // splitmix64 output mix for one accumulator value
  function automatic logic [WORD_W-1:0] splitmix_out(input logic [WORD_W-1:0] acc_val);
    logic [WORD_W-1:0] z;
    z = acc_val;
    z = (z ^ (z >> 30)) * MIX_MUL_A;
    z = (z ^ (z >> 27)) * MIX_MUL_B;
    return z ^ (z >> 31);
  endfunction

  function automatic void reseed_model(input logic [WORD_W-1:0] seed);
    logic [WORD_W-1:0] acc;
    acc = seed;
    for (int i = 0; i < NUM_WORDS; i++) begin
      acc = acc + MIX_GAMMA;
      rng_state[i] = splitmix_out(acc);
    end
  endfunction

  // xoshiro256+ output, then the state advance
  function automatic draw_result_t advance_model();
    draw_result_t      res;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] t;
    sum = rng_state[0] + rng_state[3];
    t   = rng_state[1] << 17;
    rng_state[2] = rng_state[2] ^ rng_state[0];
    rng_state[3] = rng_state[3] ^ rng_state[1];
    rng_state[1] = rng_state[1] ^ rng_state[2];
    rng_state[0] = rng_state[0] ^ rng_state[3];
    rng_state[2] = rng_state[2] ^ t;
    rng_state[3] = {rng_state[3][18:0], rng_state[3][63:19]};  // rotate left 45
    res.word     = sum;
    res.fraction = sum[WORD_W-1:FRAC_SH];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("[%0t] MISMATCH %s: got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Compare every output beat with the oldest pending draw
  always @(posedge clk_i) begin
    draw_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_draws.size() == 0) begin
        report_mismatch("output beat with no draw pending", m_axis_tdata[63:0], '0);
      end else begin
        want = pending_draws.pop_front();
        if (m_axis_tdata[63:0] !== want.word)
          report_mismatch("random_word", m_axis_tdata[63:0], want.word);
        if (m_axis_tdata[115:64] !== want.fraction)
          report_mismatch("unit_fraction", {12'h0, m_axis_tdata[115:64]},
                          {12'h0, want.fraction});
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Output-side backpressure
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (rx_hold == 0) begin
      rx_style = rx_style_e'($urandom_range(0, 3));
      rx_hold  = $urandom_range(20, 120);
    end
    rx_hold--;
    rx_phase++;
    case (rx_style)
      RX_OPEN:     m_axis_tready <= 1'b1;
      RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
      RX_PERIODIC: m_axis_tready <= ((rx_phase % 8) >= 3);
      default:     m_axis_tready <= 1'b1;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  task automatic idle_gap(input int unsigned n);
    if (n > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Offer one beat, wait for the handshake, update the model
  task automatic send_beat(input logic mode, input logic [WORD_W-1:0] seed);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= seed;
    do @(posedge clk_i); while (!s_axis_tready);
    if (mode == MODE_SEED) reseed_model(seed);
    else pending_draws.push_back(advance_model());
    // burst pacing: mostly short bursts, sometimes long runs with no gap
    burst_left--;
    if (burst_left == 0) begin
      idle_gap($urandom_range(0, 6));
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
  endtask

  task automatic send_draw();
    send_beat(MODE_DRAW, {$urandom, $urandom});  // seed bits are don't-care
  endtask

  // Hold off the sender until every pending draw has come back or DRAIN_LIMIT runs out
  task automatic wait_for_results();
    int unsigned waited;
    waited = 0;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_draws.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // State after reset matches a zero seed
  task automatic test_reset_state();
    repeat (4) send_draw();
  endtask

  task automatic test_seed_extremes();
    send_beat(MODE_SEED, 64'h0);
    repeat (2) send_draw();
    send_beat(MODE_SEED, '1);
    repeat (2) send_draw();
    // accumulator wraps to zero on the first splitmix step
    send_beat(MODE_SEED, 64'h0 - MIX_GAMMA);
    repeat (2) send_draw();
    send_beat(MODE_SEED, 64'h8000_0000_0000_0001);
    send_draw();
    // back-to-back reseeds, only the second one counts
    send_beat(MODE_SEED, 64'hAAAA_AAAA_AAAA_AAAA);
    send_beat(MODE_SEED, 64'h5555_5555_5555_5555);
    repeat (2) send_draw();
  endtask

  // Draws against a drained pipe, then a reseed right after a pause
  task automatic test_drained_pause();
    repeat (3) send_draw();
    wait_for_results();
    send_beat(MODE_SEED, {$urandom, $urandom});
    send_draw();
    wait_for_results();
  endtask

  task automatic test_random_stream();
    logic [WORD_W-1:0] seed;
    int unsigned       pick;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 88) begin
        send_draw();
      end else begin
        case ($urandom_range(0, 3))
          0:       seed = 64'h1 << $urandom_range(0, 63);
          1:       seed = ~(64'h1 << $urandom_range(0, 63));
          2:       seed = WORD_W'($urandom_range(0, 15));
          default: seed = {$urandom, $urandom};
        endcase
        send_beat(MODE_SEED, seed);
      end
      if ($urandom_range(0, 149) == 0) wait_for_results();
    end
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_DRAW;
    m_axis_tready = 1'b0;
    fail_count    = 0;
    cycle_count   = 0;
    burst_left    = 1;
    rx_style      = RX_OPEN;
    rx_hold       = 0;
    rx_phase      = 0;
    reseed_model(64'h0);

    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_seed_extremes();
    test_drained_pause();
    test_random_stream();

    wait_for_results();
    repeat (SETTLE_TIME) @(posedge clk_i);
    if (pending_draws.size() != 0)
      report_mismatch("draws left without an output beat",
                      WORD_W'(pending_draws.size()), '0);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
